FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the register access master RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A trigger that must be followed by a condition on the next clock edge.
`define ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

FILE: hw/rtl/i2cra_pkg.sv
// Types and constants shared by the register access master modules.
package i2cra_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_QUEUE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_ACK_TIMEOUT = 2'd0,
        CFG_HALF_BIT    = 2'd1,
        CFG_SETUP       = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ADDR_NACK  = 3'd1,
        ST_REG_NACK   = 3'd2,
        ST_RADDR_NACK = 3'd3,
        ST_DATA_NACK  = 3'd4,
        ST_BAD_LEN    = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_A     = 5'd1,
        PH_ST_B     = 5'd2,
        PH_RS_A     = 5'd3,
        PH_TX_SU    = 5'd4,
        PH_TX_HI    = 5'd5,
        PH_TX_LO    = 5'd6,
        PH_ACK_LO   = 5'd7,
        PH_ACK_HI   = 5'd8,
        PH_ACK_POLL = 5'd9,
        PH_RD_PRE   = 5'd10,
        PH_RD_LO    = 5'd11,
        PH_RD_HI1   = 5'd12,
        PH_RD_HI2   = 5'd13,
        PH_MA_LO    = 5'd14,
        PH_MA_HI    = 5'd15,
        PH_SP_A     = 5'd16,
        PH_SP_B     = 5'd17,
        PH_SP_C     = 5'd18
    } phase_t;

    typedef enum logic [1:0] {
        SG_ADDR  = 2'd0,
        SG_REG   = 2'd1,
        SG_RADDR = 2'd2,
        SG_DATA  = 2'd3
    } stage_t;

    typedef struct packed {
        logic [7:0] ack_timeout_ticks;
        logic [7:0] half_bit_ticks;
        logic [7:0] setup_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       sda_in;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic       is_read;
        logic [7:0] write_byte;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] fail_index;
    } result_t;

    localparam logic [7:0] CFG_ACK_TIMEOUT_RST = 8'd10;
    localparam logic [7:0] CFG_HALF_BIT_RST    = 8'd5;
    localparam logic [7:0] CFG_SETUP_RST       = 8'd1;
    localparam logic [3:0] BITS_PER_BYTE       = 4'd8;

endpackage

FILE: hw/rtl/i2cra_wq.sv
// Write byte queue: one write port and one registered read port.
module i2cra_wq #(
    parameter int WRITE_DEPTH = 16,
    parameter int IDX_W       = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [WRITE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/i2cra_core.sv
// Bus sequencer: transaction state and the per-tick update of SCL and SDA.
module i2cra_core #(
    parameter int WRITE_DEPTH = 16,
    parameter int IDX_W       = 4,
    parameter int FILL_W      = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  i2cra_pkg::item_t    item,
    input  i2cra_pkg::cfg_t     cfg,
    input  logic [7:0]          q_rd_data,
    output logic                q_wr_en,
    output logic [IDX_W-1:0]    q_wr_addr,
    output logic [7:0]          q_wr_data,
    output logic [IDX_W-1:0]    q_rd_addr,
    output i2cra_pkg::result_t  res
);

    import i2cra_pkg::*;

    phase_t            phase_reg, phase_next;
    stage_t            stage_reg, stage_next;
    logic [7:0]        tick_reg, tick_next;
    logic [3:0]        bit_reg, bit_next;
    logic [7:0]        byte_reg, byte_next;
    logic [7:0]        shift_reg, shift_next;
    logic [7:0]        ackw_reg, ackw_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  qidx_reg, qidx_next;
    logic [6:0]        dev_reg, dev_next;
    logic [7:0]        regb_reg, regb_next;
    logic [7:0]        len_reg, len_next;
    logic              rd_reg, rd_next;
    logic [2:0]        rc_reg, rc_next;
    logic [7:0]        fidx_reg, fidx_next;

    logic [7:0]        setup_eff, half_eff, timeout_eff, seg_len;
    logic [8:0]        tick_plus, byte_plus, ackw_plus;
    logic [3:0]        bit_plus;
    logic [7:0]        shift_in;
    logic [IDX_W-1:0]  qidx_inc;
    logic              last_byte;
    logic              rv_c, done_c;
    logic [7:0]        rd_c, fi_c;
    logic [2:0]        status_c;
    logic              scl_c, sda_c, drv_c;

    assign setup_eff   = (cfg.setup_ticks == 8'd0) ? 8'd1 : cfg.setup_ticks;
    assign half_eff    = (cfg.half_bit_ticks == 8'd0) ? 8'd1 : cfg.half_bit_ticks;
    assign timeout_eff = (cfg.ack_timeout_ticks == 8'd0) ? 8'd1 : cfg.ack_timeout_ticks;

    assign tick_plus = {1'b0, tick_reg} + 9'd1;
    assign byte_plus = {1'b0, byte_reg} + 9'd1;
    assign ackw_plus = {1'b0, ackw_reg} + 9'd1;
    assign bit_plus  = bit_reg + 4'd1;
    assign shift_in  = {shift_reg[6:0], item.sda_in};
    assign last_byte = (byte_plus >= {1'b0, len_reg});
    assign qidx_inc  = (qidx_reg == IDX_W'(WRITE_DEPTH - 1)) ? '0 : qidx_reg + 1'b1;

    always_comb
    begin
        unique case (phase_reg) inside
            PH_ST_A, PH_ST_B, PH_RS_A, PH_TX_SU, PH_SP_A, PH_SP_B, PH_SP_C:
                seg_len = setup_eff;
            default:
                seg_len = half_eff;
        endcase
    end

    // Bus levels always come from the state before this item's update.
    always_comb
    begin
        scl_c = 1'b1;
        sda_c = 1'b1;
        drv_c = 1'b1;
        unique case (phase_reg)
            PH_ST_B:
                sda_c = 1'b0;
            PH_RS_A:
                scl_c = 1'b0;
            PH_TX_SU, PH_TX_LO:
            begin
                scl_c = 1'b0;
                sda_c = shift_reg[7];
            end
            PH_TX_HI:
                sda_c = shift_reg[7];
            PH_ACK_LO, PH_RD_PRE, PH_RD_LO:
            begin
                scl_c = 1'b0;
                drv_c = 1'b0;
            end
            PH_ACK_HI, PH_ACK_POLL, PH_RD_HI1, PH_RD_HI2:
                drv_c = 1'b0;
            PH_MA_LO:
            begin
                scl_c = 1'b0;
                sda_c = last_byte;
            end
            PH_MA_HI:
                sda_c = last_byte;
            PH_SP_A:
            begin
                scl_c = 1'b0;
                sda_c = 1'b0;
            end
            PH_SP_B:
                sda_c = 1'b0;
            default:
            begin
                scl_c = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        stage_next = stage_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        ackw_next  = ackw_reg;
        fill_next  = fill_reg;
        qidx_next  = qidx_reg;
        dev_next   = dev_reg;
        regb_next  = regb_reg;
        len_next   = len_reg;
        rd_next    = rd_reg;
        rc_next    = rc_reg;
        fidx_next  = fidx_reg;
        rv_c       = 1'b0;
        rd_c       = 8'd0;
        done_c     = 1'b0;
        status_c   = ST_OK;
        fi_c       = 8'd0;
        q_wr_en    = 1'b0;

        case (item.opcode)
            OP_BEGIN:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    fill_next = '0;
                    if (item.is_read && item.length == 8'd0)
                    begin
                        done_c   = 1'b1;
                        status_c = ST_BAD_LEN;
                    end
                    else
                    begin
                        dev_next   = item.dev_addr;
                        regb_next  = item.reg_addr;
                        len_next   = item.length;
                        rd_next    = item.is_read;
                        stage_next = SG_ADDR;
                        rc_next    = ST_OK;
                        fidx_next  = 8'd0;
                        tick_next  = 8'd0;
                        ackw_next  = 8'd0;
                        byte_next  = 8'd0;
                        qidx_next  = '0;
                        shift_next = {item.dev_addr, 1'b0};
                        bit_next   = 4'd0;
                        phase_next = PH_ST_A;
                    end
                end
            end
            OP_QUEUE:
            begin
                if (phase_reg == PH_IDLE && fill_reg < FILL_W'(WRITE_DEPTH))
                begin
                    q_wr_en   = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            OP_TICK:
            begin
                if (phase_reg == PH_ACK_POLL)
                begin
                    if (!item.sda_in)
                    begin
                        tick_next = 8'd0;
                        bit_next  = 4'd0;
                        case (stage_reg)
                            SG_ADDR:
                            begin
                                stage_next = SG_REG;
                                shift_next = regb_reg;
                                phase_next = PH_TX_SU;
                            end
                            SG_REG:
                            begin
                                if (rd_reg)
                                begin
                                    stage_next = SG_RADDR;
                                    shift_next = {dev_reg, 1'b1};
                                    phase_next = PH_RS_A;
                                end
                                else if (len_reg == 8'd0)
                                begin
                                    bit_next   = bit_reg;
                                    phase_next = PH_SP_A;
                                end
                                else
                                begin
                                    stage_next = SG_DATA;
                                    byte_next  = 8'd0;
                                    shift_next = q_rd_data;
                                    qidx_next  = qidx_inc;
                                    phase_next = PH_TX_SU;
                                end
                            end
                            SG_RADDR:
                            begin
                                byte_next  = 8'd0;
                                shift_next = 8'd0;
                                phase_next = PH_RD_PRE;
                            end
                            default:
                            begin
                                byte_next = byte_plus[7:0];
                                if (last_byte)
                                begin
                                    bit_next   = bit_reg;
                                    phase_next = PH_SP_A;
                                end
                                else
                                begin
                                    shift_next = q_rd_data;
                                    qidx_next  = qidx_inc;
                                    phase_next = PH_TX_SU;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        ackw_next = ackw_plus[7:0];
                        if (ackw_plus >= {1'b0, timeout_eff})
                        begin
                            case (stage_reg)
                                SG_ADDR:  rc_next = ST_ADDR_NACK;
                                SG_REG:   rc_next = ST_REG_NACK;
                                SG_RADDR: rc_next = ST_RADDR_NACK;
                                default:  rc_next = ST_DATA_NACK;
                            endcase
                            fidx_next  = (stage_reg == SG_DATA) ? byte_reg : 8'd0;
                            tick_next  = 8'd0;
                            phase_next = PH_SP_A;
                        end
                    end
                end
                else if (phase_reg != PH_IDLE)
                begin
                    // The read sample lands on the last tick of the first high half.
                    if (phase_reg == PH_RD_HI1 && tick_plus >= {1'b0, seg_len})
                    begin
                        shift_next = shift_in;
                        bit_next   = bit_plus;
                        if (bit_plus >= BITS_PER_BYTE)
                        begin
                            rv_c = 1'b1;
                            rd_c = shift_in;
                        end
                    end
                    tick_next = tick_plus[7:0];
                    if (tick_plus >= {1'b0, seg_len})
                    begin
                        tick_next = 8'd0;
                        unique case (phase_reg)
                            PH_ST_A:   phase_next = PH_ST_B;
                            PH_ST_B:   phase_next = PH_TX_SU;
                            PH_RS_A:   phase_next = PH_ST_A;
                            PH_TX_SU:  phase_next = PH_TX_HI;
                            PH_TX_HI:  phase_next = PH_TX_LO;
                            PH_TX_LO:
                            begin
                                shift_next = {shift_reg[6:0], 1'b0};
                                bit_next   = bit_plus;
                                phase_next = (bit_plus >= BITS_PER_BYTE) ? PH_ACK_LO : PH_TX_SU;
                            end
                            PH_ACK_LO: phase_next = PH_ACK_HI;
                            PH_ACK_HI:
                            begin
                                ackw_next  = 8'd0;
                                phase_next = PH_ACK_POLL;
                            end
                            PH_RD_PRE: phase_next = PH_RD_LO;
                            PH_RD_LO:  phase_next = PH_RD_HI1;
                            PH_RD_HI1: phase_next = PH_RD_HI2;
                            PH_RD_HI2:
                                phase_next = (bit_reg >= BITS_PER_BYTE) ? PH_MA_LO : PH_RD_LO;
                            PH_MA_LO:  phase_next = PH_MA_HI;
                            PH_MA_HI:
                            begin
                                byte_next = byte_plus[7:0];
                                if (last_byte)
                                begin
                                    phase_next = PH_SP_A;
                                end
                                else
                                begin
                                    shift_next = 8'd0;
                                    bit_next   = 4'd0;
                                    phase_next = PH_RD_PRE;
                                end
                            end
                            PH_SP_A:   phase_next = PH_SP_B;
                            PH_SP_B:   phase_next = PH_SP_C;
                            PH_SP_C:
                            begin
                                phase_next = PH_IDLE;
                                done_c     = 1'b1;
                                status_c   = rc_reg;
                                fi_c       = fidx_reg;
                            end
                            default:   phase_next = PH_IDLE;
                        endcase
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign q_wr_addr = fill_reg[IDX_W-1:0];
    assign q_wr_data = item.write_byte;
    assign q_rd_addr = qidx_reg;

    assign res.scl_level  = scl_c;
    assign res.sda_level  = sda_c;
    assign res.sda_drive  = drv_c;
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.read_valid = rv_c;
    assign res.read_data  = rd_c;
    assign res.done_res   = done_c;
    assign res.status     = status_c;
    assign res.fail_index = fi_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            stage_reg <= SG_ADDR;
            tick_reg  <= 8'd0;
            bit_reg   <= 4'd0;
            byte_reg  <= 8'd0;
            shift_reg <= 8'd0;
            ackw_reg  <= 8'd0;
            fill_reg  <= '0;
            qidx_reg  <= '0;
            dev_reg   <= 7'd0;
            regb_reg  <= 8'd0;
            len_reg   <= 8'd0;
            rd_reg    <= 1'b0;
            rc_reg    <= ST_OK;
            fidx_reg  <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            ackw_reg  <= ackw_next;
            fill_reg  <= fill_next;
            qidx_reg  <= qidx_next;
            dev_reg   <= dev_next;
            regb_reg  <= regb_next;
            len_reg   <= len_next;
            rd_reg    <= rd_next;
            rc_reg    <= rc_next;
            fidx_reg  <= fidx_next;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_HOLDS(a_bit_count_range, bit_reg <= BITS_PER_BYTE, "bit counter past eight")
    `ASSERT_HOLDS(a_fill_bound, fill_reg <= FILL_W'(WRITE_DEPTH), "queue fill past depth")
    `ASSERT_HOLDS(a_read_valid_phase, !(fire && rv_c) || phase_reg == PH_RD_HI1, "read byte outside a high half")
    `ASSERT_NEXT(a_bad_len_idle, fire && done_c && status_c == ST_BAD_LEN, phase_reg == PH_IDLE, "rejected read left idle")

endmodule

FILE: hw/rtl/i2c_register_access_master.sv
// Top level of the register access master: channel registers, configuration and sequencer.
//
// Usage: each input transaction carries an opcode. A tick (one microsecond of bus time)
// carries the sampled SDA level; begin starts a register read or write with the device
// address, register address, length and direction; queue stores one byte to be written.
// Queue the write bytes first, then issue begin, then feed one tick per microsecond.
// Every input transaction yields exactly one output transaction with the SCL and SDA
// levels for that tick, busy, a received byte when one completes, and done with a
// status and the failing data byte index after STOP, or on a rejected zero-length read.
// An accepted input passes through the input register, then the sequencer writes its
// result into the result register. Throughput is one transaction per cycle while the
// receiver does not stall, set by the single state update per tick in the sequencer.
// A new input is taken while a finished result still waits; when the receiver stalls,
// the result register holds, and input stalls once the input register is also full.
// Reset clears the sequencer to idle, empties the queue and loads the timing registers
// with their defaults. Configuration writes take effect at once and are meant for idle.
module i2c_register_access_master #(
    parameter int WRITE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic       sda_in,
    input  logic [6:0] dev_addr,
    input  logic [7:0] reg_addr,
    input  logic [7:0] length,
    input  logic       is_read,
    input  logic [7:0] write_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_drive,
    output logic       busy_res,
    output logic       read_valid,
    output logic [7:0] read_data,
    output logic       done_res,
    output logic [2:0] status,
    output logic [7:0] fail_index
);

    import i2cra_pkg::*;

    localparam int IDX_W  = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
    localparam int FILL_W = $clog2(WRITE_DEPTH + 1);

    cfg_t             cfg_reg;
    item_t            item_reg;
    logic             in_vld_reg;
    result_t          res_reg;
    logic             out_valid_reg;
    result_t          res_c;
    logic             fire;
    logic             q_wr_en;
    logic [IDX_W-1:0] q_wr_addr;
    logic [7:0]       q_wr_data;
    logic [IDX_W-1:0] q_rd_addr;
    logic [7:0]       q_rd_data;

    // The sequencer advances when an input is held and the result register is free or being emptied.
    assign fire     = in_vld_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_vld_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_timeout_ticks <= CFG_ACK_TIMEOUT_RST;
            cfg_reg.half_bit_ticks    <= CFG_HALF_BIT_RST;
            cfg_reg.setup_ticks       <= CFG_SETUP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACK_TIMEOUT: cfg_reg.ack_timeout_ticks <= cfg_data;
                CFG_HALF_BIT:    cfg_reg.half_bit_ticks    <= cfg_data;
                CFG_SETUP:       cfg_reg.setup_ticks       <= cfg_data;
                default:         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_vld_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.opcode     <= opcode;
            item_reg.sda_in     <= sda_in;
            item_reg.dev_addr   <= dev_addr;
            item_reg.reg_addr   <= reg_addr;
            item_reg.length     <= length;
            item_reg.is_read    <= is_read;
            item_reg.write_byte <= write_byte;
        end
        if (fire)
        begin
            res_reg <= res_c;
        end
    end

    i2cra_wq #(
        .WRITE_DEPTH (WRITE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_wq (
        .clk     (clk),
        .wr_en   (q_wr_en && fire),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data)
    );

    i2cra_core #(
        .WRITE_DEPTH (WRITE_DEPTH),
        .IDX_W       (IDX_W),
        .FILL_W      (FILL_W)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .q_rd_data (q_rd_data),
        .q_wr_en   (q_wr_en),
        .q_wr_addr (q_wr_addr),
        .q_wr_data (q_wr_data),
        .q_rd_addr (q_rd_addr),
        .res       (res_c)
    );

    assign out_valid  = out_valid_reg;
    assign scl_level  = res_reg.scl_level;
    assign sda_level  = res_reg.sda_level;
    assign sda_drive  = res_reg.sda_drive;
    assign busy_res   = res_reg.busy_res;
    assign read_valid = res_reg.read_valid;
    assign read_data  = res_reg.read_data;
    assign done_res   = res_reg.done_res;
    assign status     = res_reg.status;
    assign fail_index = res_reg.fail_index;

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_result_on_fire, fire, out_valid_reg, "processed transaction lost its result")

endmodule
